/* design/bfm_pkg.sv */
package bfm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // fixed field widths
    localparam int FW_W  = 11;
    localparam int FH_W  = 12;
    localparam int ROW_W = 12;
    localparam int COL_W = 10;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // smallest frame dimension in use
    localparam int MIN_DIM = 3;

    // output queue
    localparam int FQ_DEPTH = 8;
    localparam int FQ_AW    = 3;
    localparam int FQ_CW    = 4;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // side data that travels with each word through the pipeline
    typedef struct packed {
        logic             has_res;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_meta;

endpackage

/* design/bfm_intf.sv */
interface bfm_pix_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bfm_res_if #(
    parameter int PIXEL_BITS = 8
);
    logic                           valid;
    logic                           ready;
    logic [PIXEL_BITS-1:0]          out_pixel;
    logic [bfm_pkg::ROW_W-1:0]      out_row;
    logic [bfm_pkg::COL_W-1:0]      out_col;
    logic                           last_of_frame;

    modport source (output valid, output out_pixel, output out_row, output out_col,
                    output last_of_frame, input ready);
    modport sink   (input valid, input out_pixel, input out_row, input out_col,
                    input last_of_frame, output ready);
endinterface

interface bfm_cfg_if;
    logic                 valid;
    logic                 ready;
    bfm_pkg::t_cfg_idx    index;
    bfm_pkg::t_cfg_data   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/box_filter_3x3_mean.sv */
// 3x3 rounded-mean box filter over a raster-order grayscale stream. The block takes one
// pixel word per clock while input ready is high and gives one result word per interior
// pixel, (sum + 4) / 9 of the 3x3 window around it, tagged with the centre row, column
// and a last-of-frame flag; border pixels give no word. Two line buffers, each a simple
// dual-port RAM of MAX_WIDTH entries, are read when a pixel is accepted and written back
// in the following cycle. A result passes the sum and multiply registers and waits in an
// eight-word queue; input ready drops while eight words are in the pipeline or queue.
// Line buffers need no clearing after reset. The user must write frame_width and
// frame_height only while the stream is idle; the block itself does not enforce it.
module box_filter_3x3_mean #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfm_pix_if.sink   i_pix,
    bfm_res_if.source o_res,
    bfm_cfg_if.sink   i_cfg
);
    import bfm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int WW     = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
    localparam int SUM_W  = PIXEL_BITS + 4;
    localparam int SHIFT  = SUM_W + 4;
    localparam int RCP_W  = SHIFT - 3;
    localparam int PROD_W = SUM_W + RCP_W;
    // ceil(2^SHIFT / 9): exact quotient for every sum below 2^SUM_W
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << SHIFT) + 64'd8) / 64'd9);

    // configuration
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // geometry in use
    logic [WW-1:0]   fw_ext;
    logic [WW-1:0]   w_use;
    logic [FH_W-1:0] h_use;

    assign fw_ext = WW'(r_frame_width);

    always_comb begin
        if (fw_ext < WW'(MIN_DIM)) begin
            w_use = WW'(MIN_DIM);
        end else if (fw_ext > WW'(MAX_WIDTH)) begin
            w_use = WW'(MAX_WIDTH);
        end else begin
            w_use = fw_ext;
        end
        h_use = (r_frame_height < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : r_frame_height;
    end

    // accept stage: counters, line buffer read
    logic [CNT_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [FQ_CW-1:0] r_pend;
    logic             acc;
    logic [WW-1:0]    c_ext;
    logic [WW-1:0]    col_m1;
    logic             row_end;
    logic             frame_end;
    t_meta            meta0;

    assign i_pix.ready = (r_pend < FQ_CW'(FQ_DEPTH));
    assign acc         = i_pix.valid && i_pix.ready;
    assign c_ext       = WW'(r_col);
    assign col_m1      = c_ext - WW'(1);
    assign row_end     = (c_ext >= w_use - WW'(1));
    assign frame_end   = (r_row >= h_use - FH_W'(1));

    always_comb begin
        meta0.has_res = (r_row >= ROW_W'(2)) && (r_col >= CNT_W'(2));
        meta0.row     = r_row - ROW_W'(1);
        meta0.col     = col_m1[COL_W-1:0];
        meta0.last    = row_end && frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CNT_W'(1);
            end
        end
    end

    logic [PIXEL_BITS-1:0] m_line1 [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] m_line2 [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_a1;
    logic [PIXEL_BITS-1:0] r_a2;

    logic                  r_s1_vld;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [CNT_W-1:0]      r_s1_addr;
    t_meta                 r_s1_meta;

    // consecutive words always address different entries, so the write-back in the
    // cycle after the read never meets a read of the same entry
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a1 <= m_line1[r_col];
            r_a2 <= m_line2[r_col];
        end
        if (r_s1_vld) begin
            m_line2[r_s1_addr] <= r_a1;
            m_line1[r_s1_addr] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc;
        end
        if (acc) begin
            r_s1_px   <= i_pix.pixel_in;
            r_s1_addr <= r_col;
            r_s1_meta <= meta0;
        end
    end

    // window: kept as the sums of its two older columns
    logic [SUM_W-1:0] r_cs_a;
    logic [SUM_W-1:0] r_cs_b;
    logic [SUM_W-1:0] colsum;
    logic [SUM_W-1:0] total;

    logic             r_s2_vld;
    logic [SUM_W-1:0] r_s2_sum;
    t_meta            r_s2_meta;

    assign colsum = SUM_W'(r_a2) + SUM_W'(r_a1) + SUM_W'(r_s1_px);
    assign total  = r_cs_a + r_cs_b + colsum + SUM_W'(4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        if (r_s1_vld) begin
            r_cs_a    <= r_cs_b;
            r_cs_b    <= colsum;
            r_s2_sum  <= total;
            r_s2_meta <= r_s1_meta;
        end
    end

    // divide by nine through the reciprocal
    logic              r_s3_vld;
    logic [PROD_W-1:0] r_s3_prod;
    t_meta             r_s3_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        if (r_s2_vld) begin
            r_s3_prod <= PROD_W'(r_s2_sum) * PROD_W'(RECIP);
            r_s3_meta <= r_s2_meta;
        end
    end

    // output queue
    logic [PIXEL_BITS-1:0] r_fq_pix  [FQ_DEPTH];
    t_meta                 r_fq_meta [FQ_DEPTH];
    logic [FQ_AW-1:0]      r_wr_ptr;
    logic [FQ_AW-1:0]      r_rd_ptr;
    logic [FQ_CW-1:0]      r_fcnt;
    logic [FQ_CW-1:0]      n_fcnt;
    logic [FQ_CW-1:0]      n_pend;
    logic                  push;
    logic                  pop;
    logic                  drop;

    assign push = r_s3_vld && r_s3_meta.has_res;
    assign drop = r_s3_vld && !r_s3_meta.has_res;
    assign pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fq_pix[r_wr_ptr]  <= r_s3_prod[SHIFT +: PIXEL_BITS];
            r_fq_meta[r_wr_ptr] <= r_s3_meta;
        end
    end

    always_comb begin
        n_fcnt = r_fcnt + FQ_CW'(push) - FQ_CW'(pop);
        n_pend = r_pend + FQ_CW'(acc) - FQ_CW'(drop) - FQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
            r_pend   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FQ_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FQ_AW'(1);
            end
            r_fcnt <= n_fcnt;
            r_pend <= n_pend;
        end
    end

    assign o_res.valid         = (r_fcnt != '0);
    assign o_res.out_pixel     = r_fq_pix[r_rd_ptr];
    assign o_res.out_row       = r_fq_meta[r_rd_ptr].row;
    assign o_res.out_col       = r_fq_meta[r_rd_ptr].col;
    assign o_res.last_of_frame = r_fq_meta[r_rd_ptr].last;

endmodule
